// File: hdl/tlm_pkg.sv
// Shared types, widths and helpers of the local matrix pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tlm_pkg;

  // Field widths and fixed point layout
  localparam int CW             = 32;                 // coordinate / scale word
  localparam int QW             = 16;                 // quaternion component
  localparam int QUAT_FRAC_BITS = 14;
  localparam int PW             = 2 * QW;             // quaternion product
  localparam int RW             = PW + 2;             // rotation entry, 2x sum of products
  localparam int RSH            = 2 * QUAT_FRAC_BITS; // fraction bits of a rotation entry
  localparam int SPLIT          = 17;                 // low slice of a rotation entry
  localparam int PLW            = SPLIT + 1 + CW;     // low partial product
  localparam int PHW            = RW - SPLIT + CW;    // high partial product
  localparam int PRODW          = RW + CW;            // full entry times scale

  typedef logic signed [CW-1:0] tlm_coord_t;
  typedef logic signed [QW-1:0] tlm_quat_t;
  typedef logic signed [PW-1:0] tlm_qprod_t;
  typedef logic signed [RW-1:0] tlm_rot_t;

  localparam tlm_rot_t ROT_ONE = RW'(1) <<< RSH;

  typedef struct packed {
    tlm_coord_t pos_x;
    tlm_coord_t pos_y;
    tlm_coord_t pos_z;
    tlm_quat_t  quat_w;
    tlm_quat_t  quat_x;
    tlm_quat_t  quat_y;
    tlm_quat_t  quat_z;
    tlm_coord_t scale_x;
    tlm_coord_t scale_y;
    tlm_coord_t scale_z;
  } tlm_in_t;

  typedef struct packed {
    tlm_coord_t m_r0_c0;
    tlm_coord_t m_r0_c1;
    tlm_coord_t m_r0_c2;
    tlm_coord_t m_r0_c3;
    tlm_coord_t m_r1_c0;
    tlm_coord_t m_r1_c1;
    tlm_coord_t m_r1_c2;
    tlm_coord_t m_r1_c3;
    tlm_coord_t m_r2_c0;
    tlm_coord_t m_r2_c1;
    tlm_coord_t m_r2_c2;
    tlm_coord_t m_r2_c3;
  } tlm_out_t;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } tlm_adv_t;

  // Stage 1: quaternion products, position and scale carried along
  typedef struct packed {
    tlm_coord_t [2:0] pos;
    tlm_coord_t [2:0] scale;
    tlm_qprod_t       xx;
    tlm_qprod_t       yy;
    tlm_qprod_t       zz;
    tlm_qprod_t       xy;
    tlm_qprod_t       xz;
    tlm_qprod_t       yz;
    tlm_qprod_t       wx;
    tlm_qprod_t       wy;
    tlm_qprod_t       wz;
  } tlm_s1_t;

  // Stage 2: rotation entries, row major
  typedef struct packed {
    tlm_coord_t [2:0] pos;
    tlm_coord_t [2:0] scale;
    tlm_rot_t   [8:0] r;
  } tlm_s2_t;

  function automatic tlm_qprod_t tlm_qmul(input tlm_quat_t a, input tlm_quat_t b);
    tlm_qmul = PW'(a) * PW'(b);
  endfunction

endpackage

`default_nettype wire

// File: hdl/tlm_prod.sv
// Stage 1: register the nine quaternion component products.
`timescale 1ns / 1ps
`default_nettype none

module tlm_prod (
  input  logic              clk,
  input  tlm_pkg::tlm_adv_t adv,
  input  tlm_pkg::tlm_in_t  node,
  output tlm_pkg::tlm_s1_t  s1
);
  import tlm_pkg::*;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1.pos[0]   <= node.pos_x;
      s1.pos[1]   <= node.pos_y;
      s1.pos[2]   <= node.pos_z;
      s1.scale[0] <= node.scale_x;
      s1.scale[1] <= node.scale_y;
      s1.scale[2] <= node.scale_z;
      s1.xx       <= tlm_qmul(node.quat_x, node.quat_x);
      s1.yy       <= tlm_qmul(node.quat_y, node.quat_y);
      s1.zz       <= tlm_qmul(node.quat_z, node.quat_z);
      s1.xy       <= tlm_qmul(node.quat_x, node.quat_y);
      s1.xz       <= tlm_qmul(node.quat_x, node.quat_z);
      s1.yz       <= tlm_qmul(node.quat_y, node.quat_z);
      s1.wx       <= tlm_qmul(node.quat_w, node.quat_x);
      s1.wy       <= tlm_qmul(node.quat_w, node.quat_y);
      s1.wz       <= tlm_qmul(node.quat_w, node.quat_z);
    end
  end

endmodule

`default_nettype wire

// File: hdl/tlm_rot.sv
// Stage 2: combine products into the nine rotation matrix entries.
`timescale 1ns / 1ps
`default_nettype none

module tlm_rot (
  input  logic              clk,
  input  tlm_pkg::tlm_adv_t adv,
  input  tlm_pkg::tlm_s1_t  s1,
  output tlm_pkg::tlm_s2_t  s2
);
  import tlm_pkg::*;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2.pos   <= s1.pos;
      s2.scale <= s1.scale;
      // diagonal: one minus twice the sum of squares
      s2.r[0] <= ROT_ONE - ((RW'(s1.yy) + RW'(s1.zz)) <<< 1);
      s2.r[4] <= ROT_ONE - ((RW'(s1.xx) + RW'(s1.zz)) <<< 1);
      s2.r[8] <= ROT_ONE - ((RW'(s1.xx) + RW'(s1.yy)) <<< 1);
      // off diagonal
      s2.r[1] <= (RW'(s1.xy) - RW'(s1.wz)) <<< 1;
      s2.r[2] <= (RW'(s1.xz) + RW'(s1.wy)) <<< 1;
      s2.r[3] <= (RW'(s1.xy) + RW'(s1.wz)) <<< 1;
      s2.r[5] <= (RW'(s1.yz) - RW'(s1.wx)) <<< 1;
      s2.r[6] <= (RW'(s1.xz) - RW'(s1.wy)) <<< 1;
      s2.r[7] <= (RW'(s1.yz) + RW'(s1.wx)) <<< 1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tlm_scale.sv
// Stages 3 to 5: scale one rotation entry, round and saturate to Q16.16.
`timescale 1ns / 1ps
`default_nettype none

module tlm_scale (
  input  logic                clk,
  input  tlm_pkg::tlm_adv_t   adv,
  input  tlm_pkg::tlm_rot_t   r,
  input  tlm_pkg::tlm_coord_t s,
  output tlm_pkg::tlm_coord_t m
);
  import tlm_pkg::*;

  localparam logic signed [PRODW-1:0] HALF    = PRODW'(1) <<< (RSH - 1);
  localparam logic signed [PRODW-1:0] HALF_M1 = HALF - PRODW'(1);
  localparam logic signed [PRODW-1:0] SAT_MAX = (PRODW'(1) <<< (CW - 1)) - PRODW'(1);
  localparam logic signed [PRODW-1:0] SAT_MIN = -(PRODW'(1) <<< (CW - 1));

  logic signed [SPLIT:0]      r_lo;
  logic signed [RW-SPLIT-1:0] r_hi;
  logic signed [PLW-1:0]      p_lo;
  logic signed [PHW-1:0]      p_hi;
  logic signed [PRODW-1:0]    p;
  logic signed [PRODW-1:0]    bias;
  logic signed [PRODW-1:0]    rnd;
  logic signed [PRODW-1:0]    q;

  // split the entry: unsigned low slice, signed high slice
  assign r_lo = {1'b0, r[SPLIT-1:0]};
  assign r_hi = r[RW-1:SPLIT];

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      p_lo <= PLW'(r_lo) * PLW'(s);
      p_hi <= PHW'(r_hi) * PHW'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      p <= (PRODW'(p_hi) <<< SPLIT) + PRODW'(p_lo);
    end
  end

  // round half away from zero: negative products add one less
  assign bias = p[PRODW-1] ? HALF_M1 : HALF;
  assign rnd  = p + bias;
  assign q    = rnd >>> RSH;

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      if (q > SAT_MAX) begin
        m <= SAT_MAX[CW-1:0];
      end else if (q < SAT_MIN) begin
        m <= SAT_MIN[CW-1:0];
      end else begin
        m <= q[CW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/trs_local_matrix_core.sv
// Top level: local transform matrix T*R(q)*S, five-stage pipeline.
//
//   channel | valid      | stall      | payload              | direction
//   --------+------------+------------+----------------------+----------
//   node    | node_valid | node_stall | node_data (tlm_in_t)  | in
//   mat     | mat_valid  | mat_stall  | mat_data (tlm_out_t)  | out
//
// One transaction per cycle while mat_stall does not hold the pipeline.
// Depth is set by the 34x32 scale multiply, done as two 17-bit slices
// (stage 3), summed (stage 4), then rounded and saturated (stage 5).
// Reset clears only the stage valid bits; datapath registers are not reset.
// A stalled result holds in the output register; empty stages still load,
// so bubbles collapse and node_stall rises only once every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module trs_local_matrix_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              node_valid,
  output logic              node_stall,
  input  tlm_pkg::tlm_in_t  node_data,
  output logic              mat_valid,
  input  logic              mat_stall,
  output tlm_pkg::tlm_out_t mat_data
);
  import tlm_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0]  vld;
  logic [NSTG-1:0]  ld;
  tlm_adv_t         adv;
  tlm_s1_t          s1;
  tlm_s2_t          s2;
  tlm_coord_t [2:0] pos3;
  tlm_coord_t [2:0] pos4;
  tlm_coord_t [2:0] pos5;
  tlm_coord_t [8:0] m;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    ld[NSTG-1] = !vld[NSTG-1] || !mat_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign adv.s1 = ld[0];
  assign adv.s2 = ld[1];
  assign adv.s3 = ld[2];
  assign adv.s4 = ld[3];
  assign adv.s5 = ld[4];

  assign node_stall = !ld[0];
  assign mat_valid  = vld[NSTG-1];

  // Advance valid bits with the data; hold a stage that cannot move.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= node_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  tlm_prod u_prod (
    .clk  (clk),
    .adv  (adv),
    .node (node_data),
    .s1   (s1)
  );

  tlm_rot u_rot (
    .clk (clk),
    .adv (adv),
    .s1  (s1),
    .s2  (s2)
  );

  // Column c of the rotation is multiplied by scale component c.
  for (genvar e = 0; e < 9; e++) begin : g_ent
    tlm_scale u_scale (
      .clk (clk),
      .adv (adv),
      .r   (s2.r[e]),
      .s   (s2.scale[e % 3]),
      .m   (m[e])
    );
  end

  // Carry the position alongside the scale stages.
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pos3 <= s2.pos;
    end
    if (adv.s4) begin
      pos4 <= pos3;
    end
    if (adv.s5) begin
      pos5 <= pos4;
    end
  end

  assign mat_data.m_r0_c0 = m[0];
  assign mat_data.m_r0_c1 = m[1];
  assign mat_data.m_r0_c2 = m[2];
  assign mat_data.m_r0_c3 = pos5[0];
  assign mat_data.m_r1_c0 = m[3];
  assign mat_data.m_r1_c1 = m[4];
  assign mat_data.m_r1_c2 = m[5];
  assign mat_data.m_r1_c3 = pos5[1];
  assign mat_data.m_r2_c0 = m[6];
  assign mat_data.m_r2_c1 = m[7];
  assign mat_data.m_r2_c2 = m[8];
  assign mat_data.m_r2_c3 = pos5[2];

endmodule

`default_nettype wire
